FILE: design/cia_pkg.sv
// ============================================================================
// cia_pkg: shared types and constants of the checked integer ALU
// Opcodes, status codes, controller states and the command and status bundles
// that pass between the controller and the datapath.
// ============================================================================
package cia_pkg;

    // Arithmetic width. Operands are the low DATA_WIDTH bits, sign-extended.
    localparam int DATA_WIDTH = 64;
    localparam int CNT_W = $clog2(DATA_WIDTH);

    // Stream widths: fields packed from bit 0, padded to whole bytes.
    localparam int OPC_W = 4;
    localparam int FIELD_W = 64;
    localparam int STAT_W = 2;
    localparam int IN_TDATA_W = ((OPC_W + 2 * FIELD_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((FIELD_W + STAT_W + 7) / 8) * 8;

    typedef enum logic [OPC_W-1:0] {
        OP_ADD = 4'd0,
        OP_SUB = 4'd1,
        OP_MUL = 4'd2,
        OP_FDIV = 4'd3,
        OP_MOD = 4'd4,
        OP_POW = 4'd5,
        OP_AND = 4'd6,
        OP_OR = 4'd7,
        OP_XOR = 4'd8,
        OP_SHL = 4'd9,
        OP_SAR = 4'd10,
        OP_NEG = 4'd11,
        OP_POS = 4'd12,
        OP_NOT = 4'd13
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK = 2'd0,
        ST_OVF = 2'd1,
        ST_DIV0 = 2'd2,
        ST_NEG = 2'd3
    } status_t;

    // How an item is finished after decode.
    typedef enum logic [1:0] {
        K_SIMPLE = 2'd0,
        K_MUL = 2'd1,
        K_DIV = 2'd2,
        K_POW = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_MUL,
        S_MUL_END,
        S_DIV,
        S_DIV_END,
        S_POW_CHK,
        S_DONE
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;         // capture an accepted input item
        logic imm_result;   // take the immediate result
        logic mul_start;    // load the multiplier
        logic mul_src_pow;  // multiplier operands are accumulator and lhs
        logic mul_step;     // one shift-add step
        logic mul_end;      // finish a multiply
        logic div_start;    // load the divider
        logic div_step;     // one restoring step
        logic div_end;      // floor correction
        logic pow_init;     // accumulator = 1, exponent = rhs
        logic pow_done;     // result = accumulator
        logic emit;         // move the result to the output register
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        kind_t kind;
        logic cnt_last;
        logic mul_ovf;
        logic is_pow;
        logic exp_zero;
    } sts_t;

endpackage

FILE: design/checked_int64_alu.sv
// ============================================================================
// checked_int64_alu: checked signed integer ALU with floor division
// Add, sub, mul, floor division, floor modulo, power, bitwise operations,
// checked shifts and negation, each returning a value and a status.
// ============================================================================
//  Channel | Direction | Payload
//  s_      | in        | opcode, lhs, rhs
//  m_      | out       | value, status
//
// Immediate operations are decoded and passed to the output register.
// Multiply, division and modulo run through the one-bit-per-cycle
// multiplier and divider before they reach it. Power runs at most DATA_WIDTH
// multiplies. A new item is accepted only once the last one has been passed
// to the output register.
// Reset (aresetn low) clears the controller and the output valid flag.
// A result waiting on m_ may be held while the next item is computed.
module checked_int64_alu (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // Fields from bit 0: opcode[3:0], lhs[67:4], rhs[131:68], zero fill.
    input  logic [cia_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // Fields from bit 0: value[63:0], status[65:64], zero fill.
    output logic [cia_pkg::OUT_TDATA_W-1:0]    m_tdata
);
    import cia_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Sequencing.
    cia_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Arithmetic.
    cia_datapath u_datapath (
        .aclk    (aclk),
        .s_tdata (s_tdata),
        .cmd     (cmd),
        .sts     (sts),
        .m_tdata (m_tdata)
    );

endmodule

FILE: design/cia_datapath.sv
// ============================================================================
// cia_datapath: operand registers, serial multiplier and divider
// Holds the item, computes immediate operations, and runs a shift-add
// multiplier and a restoring divider one bit per cycle under command.
// ============================================================================
module cia_datapath (
    input  logic                                aclk,
    input  logic [cia_pkg::IN_TDATA_W-1:0]      s_tdata,
    input  cia_pkg::cmd_t                       cmd,
    output cia_pkg::sts_t                       sts,
    output logic [cia_pkg::OUT_TDATA_W-1:0]     m_tdata
);
    import cia_pkg::*;

    localparam int W = DATA_WIDTH;
    localparam logic [W-1:0] SIGN_BIT = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] ONE = {{(W-1){1'b0}}, 1'b1};

    function automatic logic [W-1:0] mag(input logic [W-1:0] x);
        mag = x[W-1] ? (~x + ONE) : x;
    endfunction

    op_t                 op_reg;
    logic signed [W-1:0] a_reg, b_reg;
    logic [W-1:0]        mcand_reg;
    logic [2*W-1:0]      prod_reg;
    logic                mneg_reg;
    logic [W-1:0]        quo_reg, rem_reg, dvs_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic signed [W-1:0] acc_reg;
    logic [W-1:0]        exp_reg;
    logic signed [W-1:0] res_value_reg, out_value_reg;
    status_t             res_status_reg, out_status_reg;

    logic signed [W-1:0] imm_value;
    status_t             imm_status;
    kind_t               kind;
    logic signed [W:0]   sum_ext, dif_ext;
    logic signed [W-1:0] shl_val;
    logic [CNT_W-1:0]    sh_amt;
    logic [W:0]          mul_sum;
    logic [W-1:0]        prod_lo;
    logic                mul_ovf;
    logic [W-1:0]        mul_val;
    logic [W:0]          div_sh;
    logic                div_ge;
    logic                sign_diff;
    logic [W-1:0]        q_fix, r_sgn, r_fix;

    // Immediate operations and special cases.
    always_comb begin
        sum_ext = {a_reg[W-1], a_reg} + {b_reg[W-1], b_reg};
        dif_ext = {a_reg[W-1], a_reg} - {b_reg[W-1], b_reg};
        sh_amt = b_reg[CNT_W-1:0];
        shl_val = a_reg <<< sh_amt;
        imm_value = '0;
        imm_status = ST_OK;
        kind = K_SIMPLE;
        case (op_reg)
            OP_ADD: begin
                if (sum_ext[W] != sum_ext[W-1]) imm_status = ST_OVF;
                else imm_value = sum_ext[W-1:0];
            end
            OP_SUB: begin
                if (dif_ext[W] != dif_ext[W-1]) imm_status = ST_OVF;
                else imm_value = dif_ext[W-1:0];
            end
            OP_MUL: kind = K_MUL;
            OP_FDIV, OP_MOD: begin
                if (b_reg == '0) imm_status = ST_DIV0;
                else if (b_reg == '1) begin
                    if (op_reg == OP_FDIV) begin
                        if (a_reg == SIGN_BIT) imm_status = ST_OVF;
                        else imm_value = ~a_reg + ONE;
                    end
                end else kind = K_DIV;
            end
            OP_POW: begin
                if (b_reg[W-1]) imm_status = ST_NEG;
                else if (b_reg == '0) imm_value = ONE;
                else if (a_reg == '0) imm_value = '0;
                else if (a_reg == ONE) imm_value = ONE;
                else if (a_reg == '1) imm_value = b_reg[0] ? '1 : ONE;
                else kind = K_POW;
            end
            OP_AND: imm_value = a_reg & b_reg;
            OP_OR:  imm_value = a_reg | b_reg;
            OP_XOR: imm_value = a_reg ^ b_reg;
            OP_SHL: begin
                if (b_reg[W-1]) imm_status = ST_NEG;
                else if (a_reg == '0) imm_value = '0;
                else if (b_reg >= W) imm_status = ST_OVF;
                else if ((shl_val >>> sh_amt) != a_reg) imm_status = ST_OVF;
                else imm_value = shl_val;
            end
            OP_SAR: begin
                if (b_reg[W-1]) imm_status = ST_NEG;
                else if (b_reg >= W - 1) imm_value = a_reg[W-1] ? '1 : '0;
                else imm_value = a_reg >>> sh_amt;
            end
            OP_NEG: begin
                if (a_reg == SIGN_BIT) imm_status = ST_OVF;
                else imm_value = ~a_reg + ONE;
            end
            OP_POS: imm_value = a_reg;
            OP_NOT: imm_value = ~a_reg;
            default: imm_value = '0;
        endcase
    end

    // Multiplier step and overflow check of the finished magnitude product.
    always_comb begin
        mul_sum = {1'b0, prod_reg[2*W-1:W]} + (prod_reg[0] ? {1'b0, mcand_reg} : '0);
        prod_lo = prod_reg[W-1:0];
        mul_ovf = (prod_reg[2*W-1:W] != '0) ||
                  (mneg_reg ? (prod_lo > SIGN_BIT) : (prod_lo >= SIGN_BIT));
        mul_val = mneg_reg ? (~prod_lo + ONE) : prod_lo;
    end

    // Divider step and floor correction.
    always_comb begin
        div_sh = {rem_reg, quo_reg[W-1]};
        div_ge = div_sh >= {1'b0, dvs_reg};
        sign_diff = a_reg[W-1] ^ b_reg[W-1];
        if (sign_diff && rem_reg != '0) q_fix = ~quo_reg;
        else if (sign_diff) q_fix = ~quo_reg + ONE;
        else q_fix = quo_reg;
        r_sgn = a_reg[W-1] ? (~rem_reg + ONE) : rem_reg;
        r_fix = (sign_diff && rem_reg != '0) ? (r_sgn + b_reg) : r_sgn;
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg <= op_t'(s_tdata[OPC_W-1:0]);
            a_reg <= s_tdata[OPC_W +: W];
            b_reg <= s_tdata[OPC_W + FIELD_W +: W];
        end
        if (cmd.imm_result) begin
            res_value_reg <= imm_value;
            res_status_reg <= imm_status;
        end
        if (cmd.mul_start) begin
            cnt_reg <= '0;
            mcand_reg <= cmd.mul_src_pow ? mag(acc_reg) : mag(a_reg);
            prod_reg <= {{W{1'b0}}, cmd.mul_src_pow ? mag(a_reg) : mag(b_reg)};
            mneg_reg <= (cmd.mul_src_pow ? acc_reg[W-1] : b_reg[W-1]) ^ a_reg[W-1];
        end
        if (cmd.mul_step) begin
            cnt_reg <= cnt_reg + 1'b1;
            prod_reg <= {mul_sum, prod_reg[W-1:1]};
        end
        if (cmd.mul_end) begin
            if (mul_ovf) begin
                res_value_reg <= '0;
                res_status_reg <= ST_OVF;
            end else if (op_reg == OP_POW) begin
                acc_reg <= mul_val;
                exp_reg <= exp_reg - ONE;
            end else begin
                res_value_reg <= mul_val;
                res_status_reg <= ST_OK;
            end
        end
        if (cmd.div_start) begin
            cnt_reg <= '0;
            quo_reg <= mag(a_reg);
            rem_reg <= '0;
            dvs_reg <= mag(b_reg);
        end
        if (cmd.div_step) begin
            cnt_reg <= cnt_reg + 1'b1;
            rem_reg <= div_ge ? div_sh[W-1:0] - dvs_reg : div_sh[W-1:0];
            quo_reg <= {quo_reg[W-2:0], div_ge};
        end
        if (cmd.div_end) begin
            res_value_reg <= (op_reg == OP_FDIV) ? q_fix : r_fix;
            res_status_reg <= ST_OK;
        end
        if (cmd.pow_init) begin
            acc_reg <= ONE;
            exp_reg <= b_reg;
        end
        if (cmd.pow_done) begin
            res_value_reg <= acc_reg;
            res_status_reg <= ST_OK;
        end
        if (cmd.emit) begin
            out_value_reg <= res_value_reg;
            out_status_reg <= res_status_reg;
        end
    end

    // Status to the controller.
    assign sts.kind = kind;
    assign sts.cnt_last = (cnt_reg == CNT_W'(W - 1));
    assign sts.mul_ovf = mul_ovf;
    assign sts.is_pow = (op_reg == OP_POW);
    assign sts.exp_zero = (exp_reg == '0);

    assign m_tdata = {{(OUT_TDATA_W - FIELD_W - STAT_W){1'b0}}, out_status_reg,
                      FIELD_W'(out_value_reg)};

endmodule

FILE: design/cia_ctrl.sv
// ============================================================================
// cia_ctrl: sequencing controller of the checked integer ALU
// Steps each item through decode, serial multiply or divide, the power loop
// and hand-off to the output register.
// ============================================================================
module cia_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    input  cia_pkg::sts_t sts,
    output cia_pkg::cmd_t cmd
);
    import cia_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || m_tready;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (s_tvalid) state_next = S_DECODE;
            S_DECODE: begin
                case (sts.kind)
                    K_MUL: state_next = S_MUL;
                    K_DIV: state_next = S_DIV;
                    K_POW: state_next = S_POW_CHK;
                    default: state_next = S_DONE;
                endcase
            end
            S_MUL: if (sts.cnt_last) state_next = S_MUL_END;
            S_MUL_END: state_next = (sts.is_pow && !sts.mul_ovf) ? S_POW_CHK : S_DONE;
            S_DIV: if (sts.cnt_last) state_next = S_DIV_END;
            S_DIV_END: state_next = S_DONE;
            S_POW_CHK: state_next = sts.exp_zero ? S_DONE : S_MUL;
            S_DONE: if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        cmd = '0;
        case (state_reg)
            S_IDLE: cmd.load = s_tvalid;
            S_DECODE: begin
                case (sts.kind)
                    K_MUL: cmd.mul_start = 1'b1;
                    K_DIV: cmd.div_start = 1'b1;
                    K_POW: cmd.pow_init = 1'b1;
                    default: cmd.imm_result = 1'b1;
                endcase
            end
            S_MUL: cmd.mul_step = 1'b1;
            S_MUL_END: cmd.mul_end = 1'b1;
            S_DIV: cmd.div_step = 1'b1;
            S_DIV_END: cmd.div_end = 1'b1;
            S_POW_CHK: begin
                cmd.pow_done = sts.exp_zero;
                cmd.mul_start = !sts.exp_zero;
                cmd.mul_src_pow = 1'b1;
            end
            S_DONE: cmd.emit = out_free;
            default: cmd = '0;
        endcase
    end

    // Output valid flag.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (m_tready) out_valid_next = 1'b0;
        if (cmd.emit) out_valid_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule
